FILE: hdl/ofe_pkg.sv
// shared constants and types for the oversampled feed-forward equalizer
package ofe_pkg;

  localparam int NUM_TAPS   = 5;
  localparam int MAX_OSR    = 8;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int DEPTH      = (NUM_TAPS - 1) * MAX_OSR + 1;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int TAP_IDX_W  = $clog2(NUM_TAPS);
  localparam int NT_W       = 3;
  localparam int OSR_W      = 4;
  localparam int PRE_W      = 3;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + $clog2(NUM_TAPS);
  localparam int FRAC_SHIFT = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT = 3'd0,
    REG_OSR       = 3'd1,
    REG_PRE       = 3'd2,
    REG_TAP_0     = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic step;
    logic clear;
  } shift_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

endpackage

FILE: hdl/ofe_cell.sv
// one history cell of the delay line, loads d_in on each shift, zero on a clear
module ofe_cell (
  input  logic                clk,
  input  ofe_pkg::shift_ctl_t ctl,
  input  ofe_pkg::sample_t    d_in,
  output ofe_pkg::sample_t    q
);
  import ofe_pkg::*;

  sample_t q_r, q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctl.step) begin
      q_nxt = ctl.clear ? '0 : d_in;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

FILE: hdl/ofe_mac.sv
// tap select, multiply, sum and round/saturate pipeline with the output register
module ofe_mac (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ofe_pkg::tag_t           tag,
  output logic                    take,
  input  ofe_pkg::sample_t        hist [ofe_pkg::DEPTH],
  input  ofe_pkg::coef_t          taps [ofe_pkg::NUM_TAPS],
  input  logic [ofe_pkg::NT_W-1:0]  nt_eff,
  input  logic [ofe_pkg::OSR_W-1:0] osr_eff,
  output logic                    out_valid,
  input  logic                    out_stall,
  output ofe_pkg::sample_t        sample_out,
  output logic                    last_out
);
  import ofe_pkg::*;

  localparam logic signed [ACC_W:0] RND_HALF = (ACC_W+1)'(1 << (FRAC_SHIFT - 1));
  localparam logic signed [ACC_W:0] SAT_MAX  = (ACC_W+1)'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [ACC_W:0] SAT_MIN  = -SAT_MAX - 1;

  logic                     v1_r, v1_nxt, l1_r, l1_nxt;
  logic                     v2_r, v2_nxt, l2_r, l2_nxt;
  logic                     v3_r, v3_nxt, l3_r, l3_nxt;
  logic                     en1, en2, en3;
  logic [IDX_W-1:0]         idx [NUM_TAPS];
  logic signed [PROD_W-1:0] prod_r [NUM_TAPS];
  logic signed [PROD_W-1:0] prod_nxt [NUM_TAPS];
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W:0]    rnd, quo;
  sample_t                  dout_r, dout_nxt;

  assign en3  = !v3_r || !out_stall;
  assign en2  = !v2_r || en3;
  assign en1  = !v1_r || en2;
  assign take = en1;

  // products of the selected grid samples, taps beyond the count read as zero
  always_comb begin
    for (int j = 0; j < NUM_TAPS; j++) begin
      idx[j] = IDX_W'(j) * IDX_W'(osr_eff);
      if (NT_W'(j) < nt_eff) begin
        prod_nxt[j] = PROD_W'(hist[idx[j]] * taps[j]);
      end else begin
        prod_nxt[j] = '0;
      end
    end
  end

  always_comb begin
    acc_nxt = '0;
    for (int j = 0; j < NUM_TAPS; j++) begin
      acc_nxt = acc_nxt + ACC_W'(prod_r[j]);
    end
  end

  // round half up then floor shift, saturate to the sample range
  always_comb begin
    rnd = {acc_r[ACC_W-1], acc_r} + RND_HALF;
    quo = rnd >>> FRAC_SHIFT;
    if (quo > SAT_MAX) begin
      dout_nxt = SAMPLE_W'(SAT_MAX);
    end else if (quo < SAT_MIN) begin
      dout_nxt = SAMPLE_W'(SAT_MIN);
    end else begin
      dout_nxt = quo[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    v1_nxt = v1_r;
    l1_nxt = l1_r;
    v2_nxt = v2_r;
    l2_nxt = l2_r;
    v3_nxt = v3_r;
    l3_nxt = l3_r;
    if (en1) begin
      v1_nxt = tag.valid;
      l1_nxt = tag.last;
    end
    if (en2) begin
      v2_nxt = v1_r;
      l2_nxt = l1_r;
    end
    if (en3) begin
      v3_nxt = v2_r;
      l3_nxt = l2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l1_r <= l1_nxt;
    l2_r <= l2_nxt;
    l3_r <= l3_nxt;
    if (en1 && tag.valid) begin
      prod_r <= prod_nxt;
    end
    if (en2 && v1_r) begin
      acc_r <= acc_nxt;
    end
    if (en3 && v2_r) begin
      dout_r <= dout_nxt;
    end
  end

  assign out_valid  = v3_r;
  assign sample_out = dout_r;
  assign last_out   = l3_r;

endmodule

FILE: hdl/oversampled_ffe_fir.sv
// top level: configuration registers, history cell row, block and flush control
//
// Symbol-spaced FIR on an oversampled stream: one sample per clock is taken while the
// result side keeps up and no flush runs; each beat passes the tag stage, multiply, sum
// and round/saturate registers to the output. The beat marked last holds the input while
// precursor_taps*osr zeros shift through the history row to flush the outputs still owed;
// that number, at most 32, follows from the precursor tap and osr clamps, and the row has
// 33 history cells. A stalled output fills the four-stage pipeline before the input side
// stalls. The user must write registers only between blocks; the block does not check it.
module oversampled_ffe_fir (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [ofe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ofe_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ofe_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                in_last_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ofe_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                out_last_out
);
  import ofe_pkg::*;

  logic [NT_W-1:0]  tap_count_r, tap_count_nxt;
  logic [OSR_W-1:0] osr_r, osr_nxt;
  logic [PRE_W-1:0] pre_taps_r, pre_taps_nxt;
  coef_t            taps_r [NUM_TAPS];
  coef_t            taps_nxt [NUM_TAPS];

  logic [NT_W-1:0]  nt_eff;
  logic [OSR_W-1:0] osr_eff;
  logic [PRE_W-1:0] pre_taps_eff;
  logic [CNT_W-1:0] pre, pre_p1;

  logic             in_block_r, in_block_nxt;
  logic [CNT_W-1:0] rc_r, rc_nxt, rc_base, rc_new, pending;
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt, pend_r, pend_nxt;
  tag_t             tag_r, tag_nxt;

  logic             take, en0, in_acc, fl_step;
  shift_ctl_t       ctl, ctl0;
  sample_t          cell0_d;
  sample_t          hist [DEPTH];

  // configuration
  always_comb begin
    tap_count_nxt = tap_count_r;
    osr_nxt       = osr_r;
    pre_taps_nxt  = pre_taps_r;
    taps_nxt      = taps_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_TAP_COUNT: tap_count_nxt = cfg_data[NT_W-1:0];
        REG_OSR:       osr_nxt       = cfg_data[OSR_W-1:0];
        REG_PRE:       pre_taps_nxt  = cfg_data[PRE_W-1:0];
        default: begin
          taps_nxt[TAP_IDX_W'(cfg_index - REG_TAP_0)] = cfg_data;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= NT_W'(1);
      osr_r       <= OSR_W'(1);
      pre_taps_r  <= '0;
      for (int j = 0; j < NUM_TAPS; j++) begin
        taps_r[j] <= (j == 0) ? COEF_W'(1 << FRAC_SHIFT) : '0;
      end
    end else begin
      tap_count_r <= tap_count_nxt;
      osr_r       <= osr_nxt;
      pre_taps_r  <= pre_taps_nxt;
      taps_r      <= taps_nxt;
    end
  end

  always_comb begin
    if (tap_count_r == '0) begin
      nt_eff = NT_W'(1);
    end else if (tap_count_r > NT_W'(NUM_TAPS)) begin
      nt_eff = NT_W'(NUM_TAPS);
    end else begin
      nt_eff = tap_count_r;
    end
    if (osr_r == '0) begin
      osr_eff = OSR_W'(1);
    end else if (osr_r > OSR_W'(MAX_OSR)) begin
      osr_eff = OSR_W'(MAX_OSR);
    end else begin
      osr_eff = osr_r;
    end
    pre_taps_eff = (pre_taps_r > PRE_W'(NUM_TAPS - 1)) ? PRE_W'(NUM_TAPS - 1) : pre_taps_r;
    pre          = CNT_W'(pre_taps_eff) * CNT_W'(osr_eff);
    pre_p1       = pre + CNT_W'(1);
  end

  // handshake and shift control
  assign en0      = !tag_r.valid || take;
  assign in_stall = busy_r || !en0;
  assign in_acc   = in_valid && !in_stall;
  assign fl_step  = busy_r && en0;

  assign ctl.step   = in_acc || fl_step;
  assign ctl.clear  = in_acc && !in_block_r;
  assign ctl0.step  = ctl.step;
  assign ctl0.clear = 1'b0;
  assign cell0_d    = in_acc ? in_sample_in : '0;

  always_comb begin
    rc_base = in_block_r ? rc_r : '0;
    rc_new  = (rc_base < CNT_W'(DEPTH)) ? rc_base + CNT_W'(1) : rc_base;
    pending = (rc_new < pre_p1) ? rc_new : pre_p1;
  end

  always_comb begin
    in_block_nxt = in_block_r;
    rc_nxt       = rc_r;
    busy_nxt     = busy_r;
    rem_nxt      = rem_r;
    pend_nxt     = pend_r;
    tag_nxt      = tag_r;
    if (en0) begin
      tag_nxt.valid = 1'b0;
      tag_nxt.last  = 1'b0;
    end
    if (in_acc) begin
      rc_nxt = rc_new;
      if (!in_last_in) begin
        in_block_nxt  = 1'b1;
        tag_nxt.valid = (rc_new >= pre_p1);
      end else begin
        in_block_nxt  = 1'b0;
        tag_nxt.valid = (pre < pending);
        tag_nxt.last  = (pre == '0);
        pend_nxt      = pending;
        if (pre != '0) begin
          busy_nxt = 1'b1;
          rem_nxt  = pre - CNT_W'(1);
        end
      end
    end else if (fl_step) begin
      tag_nxt.valid = (rem_r < pend_r);
      tag_nxt.last  = (rem_r == '0);
      if (rem_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        rem_nxt = rem_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_block_r <= 1'b0;
      rc_r       <= '0;
      busy_r     <= 1'b0;
      tag_r      <= '0;
    end else begin
      in_block_r <= in_block_nxt;
      rc_r       <= rc_nxt;
      busy_r     <= busy_nxt;
      tag_r      <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    pend_r <= pend_nxt;
  end

  // history row, newest sample in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      ofe_cell u_cell (
        .clk  (clk),
        .ctl  (ctl0),
        .d_in (cell0_d),
        .q    (hist[i])
      );
    end else begin : g_body
      ofe_cell u_cell (
        .clk  (clk),
        .ctl  (ctl),
        .d_in (hist[i-1]),
        .q    (hist[i])
      );
    end
  end

  ofe_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .tag        (tag_r),
    .take       (take),
    .hist       (hist),
    .taps       (taps_r),
    .nt_eff     (nt_eff),
    .osr_eff    (osr_eff),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (out_sample_out),
    .last_out   (out_last_out)
  );

  // final flush step always issues the closing beat of the block
  a_flush_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fl_step && rem_r == '0) |=> (!busy_r && tag_r.valid && tag_r.last))
    else $error("flush end did not issue the last beat");

  a_last_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (tag_r.valid && tag_r.last) |-> !busy_r)
    else $error("last beat tagged while flush still running");

  a_no_flush_pre0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_in && pre == '0) |=> !busy_r)
    else $error("flush started with no precursor advance");

  a_flush_exit: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(rem_r) == '0)
    else $error("flush left before its count ran out");

endmodule
